[sv/bsalu_pkg.sv]
// Shared types, opcodes and field positions for the barrel shifter ALU.
`timescale 1ns / 1ps

package bsalu_pkg;

  // Data-processing opcodes, instruction bits 24:21
  typedef enum logic [3:0] {
    OP_AND = 4'b0000,
    OP_EOR = 4'b0001,
    OP_SUB = 4'b0010,
    OP_RSB = 4'b0011,
    OP_ADD = 4'b0100,
    OP_ADC = 4'b0101,
    OP_SBC = 4'b0110,
    OP_RSC = 4'b0111,
    OP_TST = 4'b1000,
    OP_TEQ = 4'b1001,
    OP_CMP = 4'b1010,
    OP_CMN = 4'b1011,
    OP_ORR = 4'b1100,
    OP_MOV = 4'b1101,
    OP_BIC = 4'b1110,
    OP_MVN = 4'b1111
  } alu_op_t;

  // Shift types, instruction bits 6:5
  typedef enum logic [1:0] {
    SH_LSL = 2'b00,
    SH_LSR = 2'b01,
    SH_ASR = 2'b10,
    SH_ROR = 2'b11
  } shift_type_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FLAG_W = 4;

  // Flag bit positions in an NZCV nibble
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  // Register number of the program counter
  localparam logic [3:0] REG_PC = 4'hF;

  // Second operand and shifter carry out
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              carry;
  } shift_res_t;

  // One executed transaction
  typedef struct packed {
    logic [DATA_W-1:0] alu_result;
    logic              write_dest;
    logic [FLAG_W-1:0] flags_out;
    logic              restore_status;
    logic [3:0]        dest_index;
  } alu_res_t;

endpackage

[sv/bsalu_shifter.sv]
// Barrel shifter: forms operand 2 and the shifter carry out.
`timescale 1ns / 1ps

module bsalu_shifter
  import bsalu_pkg::*;
(
  input  logic [DATA_W-1:0] instr_word,
  input  logic [DATA_W-1:0] rm,
  input  logic [DATA_W-1:0] rs,
  input  logic              cin,
  output shift_res_t        op2
);

  logic [4:0]          rot;
  logic [DATA_W-1:0]   imm_val;
  logic [2*DATA_W-1:0] imm_dbl;
  shift_type_t         sh_type;
  logic [7:0]          amt;
  logic                rrx;
  logic [4:0]          amt_lo;
  logic                amt_big;
  logic [DATA_W:0]     lsl_w;
  logic [DATA_W:0]     lsr_w;
  logic [DATA_W:0]     asr_w;
  logic [2*DATA_W-1:0] ror_dbl;
  logic [DATA_W-1:0]   ror_val;
  shift_res_t          reg_res;

  // Rotated 8-bit immediate
  assign rot     = {instr_word[11:8], 1'b0};
  assign imm_dbl = {24'd0, instr_word[7:0], 24'd0, instr_word[7:0]} >> rot;
  assign imm_val = imm_dbl[DATA_W-1:0];

  // Shift amount, with the immediate-zero encodings
  assign sh_type = shift_type_t'(instr_word[6:5]);
  always_comb begin
    rrx = 1'b0;
    if (instr_word[4]) begin
      amt = rs[7:0];
    end else begin
      amt = {3'd0, instr_word[11:7]};
      if (instr_word[11:7] == 5'd0) begin
        if (sh_type == SH_LSR || sh_type == SH_ASR) begin
          amt = 8'd32;
        end else if (sh_type == SH_ROR) begin
          rrx = 1'b1;
        end
      end
    end
  end

  assign amt_lo  = amt[4:0];
  assign amt_big = (amt[7:5] != 3'd0);

  // Shifts by 1..31; the extra bit catches the last bit shifted out
  assign lsl_w   = {1'b0, rm} << amt_lo;
  assign lsr_w   = {rm, 1'b0} >> amt_lo;
  assign asr_w   = $unsigned($signed({rm, 1'b0}) >>> amt_lo);
  assign ror_dbl = {rm, rm} >> amt_lo;
  assign ror_val = ror_dbl[DATA_W-1:0];

  // Register operand, with the rules for zero and 32 or more
  always_comb begin
    reg_res = '{value: rm, carry: cin};
    if (rrx) begin
      reg_res = '{value: {cin, rm[DATA_W-1:1]}, carry: rm[0]};
    end else if (amt != 8'd0) begin
      case (sh_type)
        SH_LSL: begin
          if (!amt_big) begin
            reg_res = '{value: lsl_w[DATA_W-1:0], carry: lsl_w[DATA_W]};
          end else begin
            reg_res = '{value: '0, carry: (amt == 8'd32) ? rm[0] : 1'b0};
          end
        end
        SH_LSR: begin
          if (!amt_big) begin
            reg_res = '{value: lsr_w[DATA_W:1], carry: lsr_w[0]};
          end else begin
            reg_res = '{value: '0, carry: (amt == 8'd32) ? rm[DATA_W-1] : 1'b0};
          end
        end
        SH_ASR: begin
          if (!amt_big) begin
            reg_res = '{value: asr_w[DATA_W:1], carry: asr_w[0]};
          end else begin
            reg_res = '{value: {DATA_W{rm[DATA_W-1]}}, carry: rm[DATA_W-1]};
          end
        end
        default: begin
          // ROR by a multiple of 32 passes Rm with carry bit 31
          reg_res = '{value: ror_val, carry: ror_val[DATA_W-1]};
        end
      endcase
    end
  end

  // Pick immediate or register operand
  always_comb begin
    if (instr_word[25]) begin
      op2.value = imm_val;
      op2.carry = (rot != 5'd0) ? imm_val[DATA_W-1] : cin;
    end else begin
      op2 = reg_res;
    end
  end

endmodule

[sv/bsalu_alu.sv]
// ALU: the sixteen data-processing operations and the flag update.
`timescale 1ns / 1ps

module bsalu_alu
  import bsalu_pkg::*;
(
  input  logic [DATA_W-1:0] instr_word,
  input  logic [DATA_W-1:0] rn,
  input  logic [FLAG_W-1:0] flags_in,
  input  shift_res_t        op2,
  output alu_res_t          res
);

  alu_op_t           op;
  logic              s_bit;
  logic              cin;
  logic [DATA_W-1:0] add_a;
  logic [DATA_W-1:0] add_b;
  logic              add_ci;
  logic [DATA_W:0]   sum;
  logic              add_v;
  logic [DATA_W-1:0] value;
  logic              logical;
  logic              test;
  logic              c_new;
  logic              v_new;

  assign op    = alu_op_t'(instr_word[24:21]);
  assign s_bit = instr_word[20];
  assign cin   = flags_in[FLAG_C];

  // Adder operand selection
  always_comb begin
    add_a  = rn;
    add_b  = op2.value;
    add_ci = 1'b0;
    case (op)
      OP_SUB, OP_CMP: begin
        add_b  = ~op2.value;
        add_ci = 1'b1;
      end
      OP_RSB: begin
        add_a  = op2.value;
        add_b  = ~rn;
        add_ci = 1'b1;
      end
      OP_ADC: add_ci = cin;
      OP_SBC: begin
        add_b  = ~op2.value;
        add_ci = cin;
      end
      OP_RSC: begin
        add_a  = op2.value;
        add_b  = ~rn;
        add_ci = cin;
      end
      default: add_ci = 1'b0;
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_ci};
  assign add_v = ~(add_a[DATA_W-1] ^ add_b[DATA_W-1]) & (add_a[DATA_W-1] ^ sum[DATA_W-1]);

  // Result selection
  always_comb begin
    logical = 1'b1;
    case (op)
      OP_AND, OP_TST: value = rn & op2.value;
      OP_EOR, OP_TEQ: value = rn ^ op2.value;
      OP_ORR:         value = rn | op2.value;
      OP_MOV:         value = op2.value;
      OP_BIC:         value = rn & ~op2.value;
      OP_MVN:         value = ~op2.value;
      default: begin
        value   = sum[DATA_W-1:0];
        logical = 1'b0;
      end
    endcase
  end

  assign c_new = logical ? op2.carry : sum[DATA_W];
  assign v_new = logical ? flags_in[FLAG_V] : add_v;
  assign test  = op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};

  // Outputs and flags
  always_comb begin
    res.alu_result     = value;
    res.write_dest     = ~test;
    res.restore_status = s_bit && (instr_word[15:12] == REG_PC);
    res.dest_index     = instr_word[15:12];
    if (s_bit || test) begin
      res.flags_out = {value[DATA_W-1], (value == '0), c_new, v_new};
    end else begin
      res.flags_out = flags_in;
    end
  end

endmodule

[sv/arm_barrel_shifter_alu.sv]
// Top level: input register, shifter and ALU, result register.
// Executes one ARM data-processing instruction per cycle. busy is always low,
// so a transaction is taken at every edge where start is high; its result
// shows on the out_ ports, marked by out_valid, for one cycle, once it has
// passed the input register and then the result register (with the
// barrel shifter and the 32-bit adder between them). The receiver cannot
// stall, so results must be taken when out_valid is high.
`timescale 1ns / 1ps

module arm_barrel_shifter_alu
  import bsalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] in_instr_word,
  input  logic [DATA_W-1:0] in_first_operand,
  input  logic [DATA_W-1:0] in_shifted_operand,
  input  logic [DATA_W-1:0] in_shift_source,
  input  logic [FLAG_W-1:0] in_flags_in,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_alu_result,
  output logic              out_write_dest,
  output logic [FLAG_W-1:0] out_flags_out,
  output logic              out_restore_status,
  output logic [3:0]        out_dest_index
);

  logic              stg_vld_r;
  logic [DATA_W-1:0] stg_instr_r;
  logic [DATA_W-1:0] stg_rn_r;
  logic [DATA_W-1:0] stg_rm_r;
  logic [DATA_W-1:0] stg_rs_r;
  logic [FLAG_W-1:0] stg_flags_r;
  logic              out_vld_r;
  alu_res_t          out_res_r;
  alu_res_t          out_res_nxt;
  shift_res_t        op2;

  // Never stalls
  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stg_instr_r <= in_instr_word;
      stg_rn_r    <= in_first_operand;
      stg_rm_r    <= in_shifted_operand;
      stg_rs_r    <= in_shift_source;
      stg_flags_r <= in_flags_in;
    end
  end

  // Operand 2
  bsalu_shifter u_shifter (
    .instr_word (stg_instr_r),
    .rm         (stg_rm_r),
    .rs         (stg_rs_r),
    .cin        (stg_flags_r[FLAG_C]),
    .op2        (op2)
  );

  // Operation and flags
  bsalu_alu u_alu (
    .instr_word (stg_instr_r),
    .rn         (stg_rn_r),
    .flags_in   (stg_flags_r),
    .op2        (op2),
    .res        (out_res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= stg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_vld_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_alu_result     = out_res_r.alu_result;
  assign out_write_dest     = out_res_r.write_dest;
  assign out_flags_out      = out_res_r.flags_out;
  assign out_restore_status = out_res_r.restore_status;
  assign out_dest_index     = out_res_r.dest_index;

`ifndef NO_ASSERTIONS
  // Every accepted transaction yields a result
  a_start_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

  // No result without an earlier accepted transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result without accepted transaction");

  // Status restore only with the PC as destination
  a_restore_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_restore_status) |-> (out_dest_index == REG_PC))
    else $error("status restore with non-PC destination");

  // Test ops do not write: Z must then match the discarded result
  a_test_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_dest) |->
      (out_flags_out[FLAG_Z] == (out_alu_result == '0)))
    else $error("test op flags inconsistent with result");
`endif

endmodule

[sim/dp_result_checker.sv]
// Result checker for the barrel shifter ALU: predicts each transaction and compares.
`timescale 1ns / 1ps

module dp_result_checker
  import bsalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [DATA_W-1:0] in_instr_word,
  input  logic [DATA_W-1:0] in_first_operand,
  input  logic [DATA_W-1:0] in_shifted_operand,
  input  logic [DATA_W-1:0] in_shift_source,
  input  logic [FLAG_W-1:0] in_flags_in,
  input  logic              out_valid,
  input  logic [DATA_W-1:0] out_alu_result,
  input  logic              out_write_dest,
  input  logic [FLAG_W-1:0] out_flags_out,
  input  logic              out_restore_status,
  input  logic [3:0]        out_dest_index,
  output int unsigned       fail_count,
  output int unsigned       outstanding
);

  alu_res_t    expected_results[$];
  alu_res_t    want;
  alu_res_t    got;
  int unsigned errors;

  initial begin
    errors = 0;
    fail_count = 0;
    outstanding = 0;
  end

  // Barrel shifter for a register operand, architectural rules for odd amounts
  function automatic shift_res_t shift_rm(logic [DATA_W-1:0] rm, shift_type_t kind,
                                          int unsigned amt, logic rrx, logic cin);
    shift_res_t  sr;
    int unsigned n;
    sr.value = rm;
    sr.carry = cin;
    n = amt % 32;
    if (rrx) begin
      sr.value = {cin, rm[31:1]};
      sr.carry = rm[0];
    end else if (amt != 0) begin
      case (kind)
        SH_LSL: begin
          if (amt < 32) begin
            sr.value = rm << amt;
            sr.carry = rm[32 - amt];
          end else begin
            sr.value = '0;
            sr.carry = (amt == 32) ? rm[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (amt < 32) begin
            sr.value = rm >> amt;
            sr.carry = rm[amt - 1];
          end else begin
            sr.value = '0;
            sr.carry = (amt == 32) ? rm[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (amt < 32) begin
            sr.value = $signed(rm) >>> amt;
            sr.carry = rm[amt - 1];
          end else begin
            sr.value = {DATA_W{rm[31]}};
            sr.carry = rm[31];
          end
        end
        default: begin
          // ROR by a multiple of 32 leaves the value, carry is bit 31
          if (n == 0) begin
            sr.carry = rm[31];
          end else begin
            sr.value = (rm >> n) | (rm << (32 - n));
            sr.carry = sr.value[31];
          end
        end
      endcase
    end
    return sr;
  endfunction

  // Expected outcome of one data-processing instruction
  function automatic alu_res_t execute_dp(logic [DATA_W-1:0] instr, logic [DATA_W-1:0] rn,
                                          logic [DATA_W-1:0] rm, logic [DATA_W-1:0] rs,
                                          logic [FLAG_W-1:0] flags);
    alu_res_t          r;
    alu_op_t           op;
    shift_type_t       kind;
    shift_res_t        op2;
    logic [DATA_W-1:0] imm32;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W:0]   sum;
    logic              cin;
    logic              ci;
    logic              c;
    logic              v;
    logic              rrx;
    logic              logical;
    logic              test;
    logic              upd;
    int unsigned       rot_amt;
    int unsigned       amt;

    op = alu_op_t'(instr[24:21]);
    cin = flags[FLAG_C];
    rrx = 1'b0;
    a = '0;
    b = '0;
    ci = 1'b0;
    res = '0;
    logical = 1'b1;

    // Second operand: rotated immediate or shifted Rm
    if (instr[25]) begin
      imm32 = {24'h0, instr[7:0]};
      rot_amt = instr[11:8] * 2;
      if (rot_amt == 0) begin
        op2.value = imm32;
        op2.carry = cin;
      end else begin
        op2.value = (imm32 >> rot_amt) | (imm32 << (32 - rot_amt));
        op2.carry = op2.value[31];
      end
    end else begin
      kind = shift_type_t'(instr[6:5]);
      if (instr[4]) begin
        amt = rs[7:0];
      end else begin
        amt = instr[11:7];
        // immediate amount zero: LSR/ASR mean 32, ROR means RRX
        if (amt == 0) begin
          if (kind == SH_LSR || kind == SH_ASR) amt = 32;
          else if (kind == SH_ROR) rrx = 1'b1;
        end
      end
      op2 = shift_rm(rm, kind, amt, rrx, cin);
    end

    // ALU operation
    case (op)
      OP_AND, OP_TST: res = rn & op2.value;
      OP_EOR, OP_TEQ: res = rn ^ op2.value;
      OP_SUB, OP_CMP: begin a = rn; b = ~op2.value; ci = 1'b1; logical = 1'b0; end
      OP_RSB:         begin a = op2.value; b = ~rn; ci = 1'b1; logical = 1'b0; end
      OP_ADD, OP_CMN: begin a = rn; b = op2.value; ci = 1'b0; logical = 1'b0; end
      OP_ADC:         begin a = rn; b = op2.value; ci = cin; logical = 1'b0; end
      OP_SBC:         begin a = rn; b = ~op2.value; ci = cin; logical = 1'b0; end
      OP_RSC:         begin a = op2.value; b = ~rn; ci = cin; logical = 1'b0; end
      OP_ORR:         res = rn | op2.value;
      OP_MOV:         res = op2.value;
      OP_BIC:         res = rn & ~op2.value;
      default:        res = ~op2.value;
    endcase

    if (logical) begin
      c = op2.carry;
      v = flags[FLAG_V];
    end else begin
      sum = {1'b0, a} + {1'b0, b} + ci;
      res = sum[DATA_W-1:0];
      c = sum[DATA_W];
      v = ~(a[31] ^ b[31]) & (a[31] ^ res[31]);
    end

    test = op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
    upd = instr[20] | test;

    r.alu_result = res;
    r.write_dest = ~test;
    r.flags_out = upd ? {res[31], (res == '0), c, v} : flags;
    r.restore_status = (instr[15:12] == REG_PC) && instr[20];
    r.dest_index = instr[15:12];
    return r;
  endfunction

  // Check results first, then queue the prediction for a new transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        got = {out_alu_result, out_write_dest, out_flags_out, out_restore_status,
               out_dest_index};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no transaction pending: res=%h wr=%b fl=%h rs=%b rd=%0d",
                     $time, got.alu_result, got.write_dest, got.flags_out,
                     got.restore_status, got.dest_index);
        end else begin
          want = expected_results.pop_front();
          if (got.alu_result !== want.alu_result || got.write_dest !== want.write_dest ||
              got.flags_out !== want.flags_out ||
              got.restore_status !== want.restore_status ||
              got.dest_index !== want.dest_index) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp res=%h wr=%b fl=%h rs=%b rd=%0d, got res=%h wr=%b fl=%h rs=%b rd=%0d",
                       $time, want.alu_result, want.write_dest, want.flags_out,
                       want.restore_status, want.dest_index, got.alu_result,
                       got.write_dest, got.flags_out, got.restore_status, got.dest_index);
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(execute_dp(in_instr_word, in_first_operand,
                                              in_shifted_operand, in_shift_source,
                                              in_flags_in));
    end
    outstanding <= expected_results.size();
    fail_count <= errors;
  end

endmodule

[sim/arm_barrel_shifter_alu_tb.sv]
// Testbench top for the barrel shifter ALU: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module arm_barrel_shifter_alu_tb;
  import bsalu_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [DATA_W-1:0] in_instr_word;
  logic [DATA_W-1:0] in_first_operand;
  logic [DATA_W-1:0] in_shifted_operand;
  logic [DATA_W-1:0] in_shift_source;
  logic [FLAG_W-1:0] in_flags_in;
  logic              out_valid;
  logic [DATA_W-1:0] out_alu_result;
  logic              out_write_dest;
  logic [FLAG_W-1:0] out_flags_out;
  logic              out_restore_status;
  logic [3:0]        out_dest_index;
  int unsigned       fail_count;
  int unsigned       outstanding;

  int unsigned       items_sent = 0;
  logic              idle_on = 1'b0;

  arm_barrel_shifter_alu DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_instr_word      (in_instr_word),
    .in_first_operand   (in_first_operand),
    .in_shifted_operand (in_shifted_operand),
    .in_shift_source    (in_shift_source),
    .in_flags_in        (in_flags_in),
    .out_valid          (out_valid),
    .out_alu_result     (out_alu_result),
    .out_write_dest     (out_write_dest),
    .out_flags_out      (out_flags_out),
    .out_restore_status (out_restore_status),
    .out_dest_index     (out_dest_index)
  );

  dp_result_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_instr_word      (in_instr_word),
    .in_first_operand   (in_first_operand),
    .in_shifted_operand (in_shifted_operand),
    .in_shift_source    (in_shift_source),
    .in_flags_in        (in_flags_in),
    .out_valid          (out_valid),
    .out_alu_result     (out_alu_result),
    .out_write_dest     (out_write_dest),
    .out_flags_out      (out_flags_out),
    .out_restore_status (out_restore_status),
    .out_dest_index     (out_dest_index),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Data-processing word: cond AL, Rn r1
  function automatic logic [31:0] dp_word(logic imm, alu_op_t op, logic s, logic [3:0] rd,
                                          logic [11:0] op2);
    return {4'hE, 2'b00, imm, op, s, 4'h1, rd, op2};
  endfunction

  // Operand field: Rm r2 shifted by an immediate amount
  function automatic logic [11:0] shift_by_imm(int unsigned amt, shift_type_t kind);
    return {amt[4:0], kind, 1'b0, 4'h2};
  endfunction

  // Operand field: Rm r2 shifted by Rs r3
  function automatic logic [11:0] shift_by_reg(shift_type_t kind);
    return {4'h3, 1'b0, kind, 1'b1, 4'h2};
  endfunction

  // Operand values biased toward the corners
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Drive one transaction after a random idle gap, return once accepted
  task automatic send_item(input logic [31:0] instr, input logic [31:0] rn,
                           input logic [31:0] rm, input logic [31:0] rs,
                           input logic [3:0] flags);
    int gap;
    if (items_sent % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
    gap = idle_on ? $urandom_range(0, 17) : 0;
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_instr_word <= instr;
    in_first_operand <= rn;
    in_shifted_operand <= rm;
    in_shift_source <= rs;
    in_flags_in <= flags;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("arm_barrel_shifter_alu_tb failed");
    $finish;
  end

  initial begin
    logic [31:0] word;
    logic [31:0] rs;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_instr_word <= '0;
    in_first_operand <= '0;
    in_shifted_operand <= '0;
    in_shift_source <= '0;
    in_flags_in <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: immediates with and without rotation
    send_item(dp_word(1'b1, OP_MOV, 1'b1, 4'd1, 12'h000), 32'h0, 32'h0, 32'h0, 4'b0010);
    send_item(dp_word(1'b1, OP_MOV, 1'b1, 4'd2, 12'hFFF), 32'h0, 32'h0, 32'h0, 4'b0000);
    send_item(dp_word(1'b1, OP_MVN, 1'b1, 4'd15, 12'h180), 32'h0, 32'h0, 32'h0, 4'b1111);
    send_item(dp_word(1'b1, OP_BIC, 1'b0, 4'd3, 12'h4FF), 32'hFFFF_FFFF, 32'h0, 32'h0,
              4'b0101);
    send_item(dp_word(1'b1, OP_CMP, 1'b1, 4'd15, 12'h001), 32'h0000_0001, 32'h0, 32'h0,
              4'b0000);
    send_item(dp_word(1'b1, OP_ADD, 1'b1, 4'd4, 12'h001), 32'hFFFF_FFFF, 32'h0, 32'h0,
              4'b0000);

    // Directed: immediate shift amounts of zero, and an add with LSL by 31
    send_item(dp_word(1'b0, OP_AND, 1'b1, 4'd5, shift_by_imm(0, SH_LSL)), 32'hFFFF_FFFF,
              32'h8000_0000, 32'h0, 4'b0010);
    send_item(dp_word(1'b0, OP_EOR, 1'b1, 4'd6, shift_by_imm(0, SH_LSR)), 32'h0,
              32'h8000_0000, 32'h0, 4'b0000);
    send_item(dp_word(1'b0, OP_SUB, 1'b1, 4'd7, shift_by_imm(0, SH_ASR)), 32'h0,
              32'h8000_0000, 32'h0, 4'b0000);
    send_item(dp_word(1'b0, OP_RSB, 1'b1, 4'd8, shift_by_imm(0, SH_ROR)), 32'h0,
              32'h0000_0003, 32'h0, 4'b0010);
    send_item(dp_word(1'b0, OP_ADD, 1'b1, 4'd9, shift_by_imm(31, SH_LSL)), 32'h7FFF_FFFF,
              32'h0000_0001, 32'h0, 4'b0000);
    send_item(dp_word(1'b0, OP_MVN, 1'b0, 4'd15, shift_by_imm(0, SH_ROR)), 32'h0,
              32'h0000_0001, 32'h0, 4'b1010);

    // Directed: register shifts by 0, 32 and beyond, and one by 4
    send_item(dp_word(1'b0, OP_ADC, 1'b1, 4'd10, shift_by_reg(SH_LSL)), 32'h1234_5678,
              32'h0F0F_0F0F, 32'hFFFF_FF00, 4'b0010);
    send_item(dp_word(1'b0, OP_SBC, 1'b1, 4'd11, shift_by_reg(SH_LSL)), 32'h0,
              32'h0000_0001, 32'h0000_0020, 4'b0000);
    send_item(dp_word(1'b0, OP_RSC, 1'b1, 4'd12, shift_by_reg(SH_LSR)), 32'h8000_0000,
              32'h8000_0000, 32'h0000_0020, 4'b0010);
    send_item(dp_word(1'b0, OP_TST, 1'b0, 4'd13, shift_by_reg(SH_LSL)), 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h0000_0021, 4'b1111);
    send_item(dp_word(1'b0, OP_TEQ, 1'b0, 4'd14, shift_by_reg(SH_LSR)), 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h0000_00C8, 4'b0000);
    send_item(dp_word(1'b0, OP_CMP, 1'b0, 4'd0, shift_by_reg(SH_ASR)), 32'h0,
              32'h8000_0000, 32'h0000_0020, 4'b0000);
    send_item(dp_word(1'b0, OP_CMN, 1'b1, 4'd1, shift_by_reg(SH_ASR)), 32'h8000_0000,
              32'h7FFF_FFFF, 32'h0000_00FF, 4'b0011);
    send_item(dp_word(1'b0, OP_ORR, 1'b1, 4'd2, shift_by_reg(SH_ROR)), 32'h0,
              32'h8000_0001, 32'h0000_0040, 4'b0000);
    send_item(dp_word(1'b0, OP_MOV, 1'b1, 4'd3, shift_by_reg(SH_ROR)), 32'h0,
              32'h0000_000F, 32'h0000_0004, 4'b0000);

    // Directed: all-zero and all-one words
    send_item(32'h0000_0000, 32'h0, 32'h0, 32'h0, 4'h0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);

    // Random: mostly well-formed data-processing words, corner-biased operands
    for (int i = 0; i < 1250; i++) begin
      word = $urandom;
      if ($urandom_range(0, 3) != 0) word[27:26] = 2'b00;
      rs = $urandom;
      case ($urandom_range(0, 5))
        0: rs[7:0] = 8'd0;
        1: rs[7:0] = 8'($urandom_range(1, 31));
        2: rs[7:0] = 8'd32;
        3: rs[7:0] = 8'($urandom_range(33, 255));
        4: rs[7:0] = {3'($urandom_range(1, 7)), 5'b0};
        default: ;
      endcase
      send_item(word, pick_operand(), pick_operand(), rs, 4'($urandom_range(0, 15)));
    end
    start <= 1'b0;

    // Drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (fail_count == 0) begin
      $display("arm_barrel_shifter_alu_tb passed");
    end else begin
      $display("arm_barrel_shifter_alu_tb failed");
    end
    $finish;
  end

endmodule
